// File: rtl/pdn_pkg.sv
// Package for the PLL phase detector / notch / PI unit.
// Sequencer state type, register map indexes and fixed widths; no dependencies.
`default_nettype none

package pdn_pkg;

   localparam int SMP_W  = 16;   // Q1.15 samples
   localparam int VAL_W  = 24;   // Q8.16 internal values
   localparam int COEF_W = 20;   // Q4.16 coefficients
   localparam int PROD_W = 48;   // multiplier product / accumulator
   localparam int REG_W  = 48;   // widest register
   localparam int CSR_DW = 64;   // csr data bus
   localparam int CSR_AW = 6;    // 8 registers at 8-byte spacing

   localparam logic [2:0] REG_NOTCH_ENABLE  = 3'd0;
   localparam logic [2:0] REG_COEF_B0       = 3'd1;
   localparam logic [2:0] REG_COEF_B1       = 3'd2;
   localparam logic [2:0] REG_COEF_B2       = 3'd3;
   localparam logic [2:0] REG_COEF_A1       = 3'd4;
   localparam logic [2:0] REG_COEF_A2       = 3'd5;
   localparam logic [2:0] REG_GAINS         = 3'd6;
   localparam logic [2:0] REG_OUTPUT_LIMITS = 3'd7;

   localparam logic [COEF_W-1:0] COEF_B0_RESET    = 20'h10000;
   localparam logic [REG_W-1:0]  OUT_LIMITS_RESET = 48'h7FFFFF_800000;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ERR,     // sample * cosine
      S_ERRW,    // scale phase error
      S_N0,      // b0 * err
      S_N1,      // b1 * x1
      S_N2,      // b2 * x2
      S_N3,      // a1 * y1
      S_N4,      // a2 * y2
      S_NSUM,    // close notch sum, update history
      S_KI,      // ki * err
      S_INT,     // integrator add, kp * err
      S_ICLAMP,  // integrator clamp
      S_OUT,     // proportional + integrator
      S_OCLAMP   // output clamp, hand to output register
   } state_type;

endpackage

`default_nettype wire

// File: rtl/pll_phase_detect_notch_pi_unit.sv
// Single-phase PLL phase detector, optional notch biquad and PI loop filter; depends on pdn_pkg.
// A new transaction is accepted only while the sequencer is idle; the notch steps are skipped
// when the notch is off, and the output clamp step waits until the output register is free. A single
// shared 24x24 multiplier with a registered product is stepped by the sequencer.
// Reset (synchronous, active high) restores register defaults and clears history.
// A result waits in the output register; the next transaction may start meanwhile.
`default_nettype none

module pll_phase_detect_notch_pi_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // input channel
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic signed [pdn_pkg::SMP_W-1:0]   req_in_sample,
   input  wire logic signed [pdn_pkg::SMP_W-1:0]   req_cos_ref,
   // result channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [pdn_pkg::VAL_W-1:0]        rsp_control_out,
   output logic signed [pdn_pkg::VAL_W-1:0]        rsp_filtered_error,
   // configuration port
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [pdn_pkg::CSR_AW-1:0]         paddr,
   input  wire logic [pdn_pkg::CSR_DW-1:0]         pwdata,
   output logic [pdn_pkg::CSR_DW-1:0]              prdata,
   output logic                                    pready
);

   import pdn_pkg::*;

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   logic                     notch_en_ff;
   logic signed [COEF_W-1:0] b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic [REG_W-1:0]         gains_ff;
   logic [REG_W-1:0]         limits_ff;
   logic                     csr_wr;
   logic [2:0]               csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[CSR_AW-1:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         notch_en_ff <= 1'b0;
         b0_ff       <= COEF_B0_RESET;
         b1_ff       <= '0;
         b2_ff       <= '0;
         a1_ff       <= '0;
         a2_ff       <= '0;
         gains_ff    <= '0;
         limits_ff   <= OUT_LIMITS_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_NOTCH_ENABLE:  notch_en_ff <= pwdata[0];
            REG_COEF_B0:       b0_ff       <= pwdata[COEF_W-1:0];
            REG_COEF_B1:       b1_ff       <= pwdata[COEF_W-1:0];
            REG_COEF_B2:       b2_ff       <= pwdata[COEF_W-1:0];
            REG_COEF_A1:       a1_ff       <= pwdata[COEF_W-1:0];
            REG_COEF_A2:       a2_ff       <= pwdata[COEF_W-1:0];
            REG_GAINS:         gains_ff    <= pwdata[REG_W-1:0];
            REG_OUTPUT_LIMITS: limits_ff   <= pwdata[REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_NOTCH_ENABLE:  prdata = CSR_DW'(notch_en_ff);
         REG_COEF_B0:       prdata = CSR_DW'(unsigned'(b0_ff));
         REG_COEF_B1:       prdata = CSR_DW'(unsigned'(b1_ff));
         REG_COEF_B2:       prdata = CSR_DW'(unsigned'(b2_ff));
         REG_COEF_A1:       prdata = CSR_DW'(unsigned'(a1_ff));
         REG_COEF_A2:       prdata = CSR_DW'(unsigned'(a2_ff));
         REG_GAINS:         prdata = CSR_DW'(gains_ff);
         REG_OUTPUT_LIMITS: prdata = CSR_DW'(limits_ff);
         default:           prdata = '0;
      endcase
   end

   // register fields as signed Q8.16
   logic signed [VAL_W-1:0] kp, ki, lim_hi, lim_lo;
   assign kp     = gains_ff[2*VAL_W-1:VAL_W];
   assign ki     = gains_ff[VAL_W-1:0];
   assign lim_hi = limits_ff[2*VAL_W-1:VAL_W];
   assign lim_lo = limits_ff[VAL_W-1:0];

   // ---------------------------------------------------------------------------
   // Helpers
   // ---------------------------------------------------------------------------
   function automatic logic signed [VAL_W-1:0] sat24(input logic signed [32:0] v);
      logic signed [32:0] vmax, vmin;
      vmax = 33'sd8388607;
      vmin = -33'sd8388608;
      if (v > vmax)      sat24 = vmax[VAL_W-1:0];
      else if (v < vmin) sat24 = vmin[VAL_W-1:0];
      else               sat24 = v[VAL_W-1:0];
   endfunction

   // upper bound checked first; an inverted pair keeps this order
   function automatic logic signed [VAL_W-1:0] clamp_lim(
      input logic signed [VAL_W-1:0] v,
      input logic signed [VAL_W-1:0] hi,
      input logic signed [VAL_W-1:0] lo);
      if (v > hi)      clamp_lim = hi;
      else if (v < lo) clamp_lim = lo;
      else             clamp_lim = v;
   endfunction

   // ---------------------------------------------------------------------------
   // Datapath and sequencer registers
   // ---------------------------------------------------------------------------
   state_type state_ff, state_in;

   logic signed [SMP_W-1:0]  smp_ff,   smp_in;
   logic signed [SMP_W-1:0]  cos_ff,   cos_in;
   logic signed [PROD_W-1:0] prod_ff,  prod_in;
   logic signed [PROD_W-1:0] acc_ff,   acc_in;
   logic signed [VAL_W-1:0]  err_ff,   err_in;
   logic signed [VAL_W-1:0]  x1_ff,    x1_in;
   logic signed [VAL_W-1:0]  x2_ff,    x2_in;
   logic signed [VAL_W-1:0]  y1_ff,    y1_in;
   logic signed [VAL_W-1:0]  y2_ff,    y2_in;
   logic signed [VAL_W-1:0]  integ_ff, integ_in;
   logic signed [VAL_W-1:0]  tmp_ff,   tmp_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0]  rsp_ctrl_ff,  rsp_ctrl_in;
   logic signed [VAL_W-1:0]  rsp_ferr_ff,  rsp_ferr_in;

   // shared multiplier operands
   logic                     mul_en;
   logic signed [VAL_W-1:0]  mul_a, mul_b;

   // sums that feed saturation
   logic signed [PROD_W-1:0] notch_sum;
   logic signed [32:0]       notch_scaled;
   logic signed [32:0]       int_sum;
   logic signed [32:0]       out_sum;
   logic                     req_acc;
   logic                     out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign notch_sum    = acc_ff - prod_ff;
   assign notch_scaled = 33'(signed'(notch_sum[PROD_W-1:16]));
   assign int_sum      = 33'(signed'(prod_ff[PROD_W-1:16])) + 33'(integ_ff);
   assign out_sum      = 33'(signed'(prod_ff[PROD_W-1:16])) + 33'(integ_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_acc) state_in = S_ERR;
         S_ERR:    state_in = S_ERRW;
         S_ERRW:   state_in = notch_en_ff ? S_N0 : S_KI;
         S_N0:     state_in = S_N1;
         S_N1:     state_in = S_N2;
         S_N2:     state_in = S_N3;
         S_N3:     state_in = S_N4;
         S_N4:     state_in = S_NSUM;
         S_NSUM:   state_in = S_KI;
         S_KI:     state_in = S_INT;
         S_INT:    state_in = S_ICLAMP;
         S_ICLAMP: state_in = S_OUT;
         S_OUT:    state_in = S_OCLAMP;
         S_OCLAMP: if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath controls and register next values
   always_comb begin
      smp_in       = smp_ff;
      cos_in       = cos_ff;
      acc_in       = acc_ff;
      err_in       = err_ff;
      x1_in        = x1_ff;
      x2_in        = x2_ff;
      y1_in        = y1_ff;
      y2_in        = y2_ff;
      integ_in     = integ_ff;
      tmp_in       = tmp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ctrl_in  = rsp_ctrl_ff;
      rsp_ferr_in  = rsp_ferr_ff;
      mul_en       = 1'b0;
      mul_a        = err_ff;
      mul_b        = err_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               smp_in = req_in_sample;
               cos_in = req_cos_ref;
            end
         end
         S_ERR: begin
            mul_en = 1'b1;
            mul_a  = VAL_W'(smp_ff);
            mul_b  = VAL_W'(cos_ff);
         end
         S_ERRW: begin
            // Q2.30 product, floor shift by 14; always fits in 24 bits
            err_in = prod_ff[VAL_W+13:14];
         end
         S_N0: begin
            mul_en = 1'b1;
            mul_a  = VAL_W'(b0_ff);
            mul_b  = err_ff;
         end
         S_N1: begin
            mul_en = 1'b1;
            mul_a  = VAL_W'(b1_ff);
            mul_b  = x1_ff;
            acc_in = prod_ff;
         end
         S_N2: begin
            mul_en = 1'b1;
            mul_a  = VAL_W'(b2_ff);
            mul_b  = x2_ff;
            acc_in = acc_ff + prod_ff;
         end
         S_N3: begin
            mul_en = 1'b1;
            mul_a  = VAL_W'(a1_ff);
            mul_b  = y1_ff;
            acc_in = acc_ff + prod_ff;
         end
         S_N4: begin
            mul_en = 1'b1;
            mul_a  = VAL_W'(a2_ff);
            mul_b  = y2_ff;
            acc_in = acc_ff - prod_ff;
         end
         S_NSUM: begin
            x2_in  = x1_ff;
            x1_in  = err_ff;
            y2_in  = y1_ff;
            y1_in  = sat24(notch_scaled);
            err_in = sat24(notch_scaled);
         end
         S_KI: begin
            mul_en = 1'b1;
            mul_a  = ki;
            mul_b  = err_ff;
         end
         S_INT: begin
            integ_in = sat24(int_sum);
            mul_en   = 1'b1;
            mul_a    = kp;
            mul_b    = err_ff;
         end
         S_ICLAMP: begin
            integ_in = clamp_lim(integ_ff, lim_hi, lim_lo);
         end
         S_OUT: begin
            tmp_in = sat24(out_sum);
         end
         S_OCLAMP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ctrl_in  = clamp_lim(tmp_ff, lim_hi, lim_lo);
               rsp_ferr_in  = err_ff;
            end
         end
         default: ;
      endcase

      prod_in = mul_en ? (PROD_W'(mul_a) * PROD_W'(mul_b)) : prod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         x1_ff        <= '0;
         x2_ff        <= '0;
         y1_ff        <= '0;
         y2_ff        <= '0;
         integ_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         x1_ff        <= x1_in;
         x2_ff        <= x2_in;
         y1_ff        <= y1_in;
         y2_ff        <= y2_in;
         integ_ff     <= integ_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      smp_ff      <= smp_in;
      cos_ff      <= cos_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      err_ff      <= err_in;
      tmp_ff      <= tmp_in;
      rsp_ctrl_ff <= rsp_ctrl_in;
      rsp_ferr_ff <= rsp_ferr_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_control_out    = rsp_ctrl_ff;
   assign rsp_filtered_error = rsp_ferr_ff;

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_ERR))
      else $error("accepted transaction did not start the sequencer");

   a_rsp_from_clamp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OCLAMP))
      else $error("result valid raised outside the output clamp step");

   a_bypass_holds_history: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ERRW && !notch_en_ff) |=>
         ($stable(x1_ff) && $stable(x2_ff) && $stable(y1_ff) && $stable(y2_ff)))
      else $error("notch history changed while the notch is bypassed");

   a_integ_in_limits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ICLAMP && lim_hi >= lim_lo) |=>
         (integ_ff <= $past(lim_hi) && integ_ff >= $past(lim_lo)))
      else $error("integrator outside the output limits after clamp");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ctrl_ff)))
      else $error("pending result overwritten");

endmodule

`default_nettype wire
